// ----- hw/rtl/chain_root_small_prime_classifier_defines.svh -----
// Assertion macros shared by the chain root classifier RTL.
`ifndef CHAIN_ROOT_SMALL_PRIME_CLASSIFIER_DEFINES_SVH
`define CHAIN_ROOT_SMALL_PRIME_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define CRSPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define CRSPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/crspc_pkg.sv -----
// Package with constants, types and tables for the chain root classifier.
`timescale 1ns / 1ps
package crspc_pkg;

    localparam int NUM_PRIMES     = 10;
    localparam int CHAIN_MAX      = 25;
    localparam int MAX_BIT_LENGTH = 512;
    localparam int PRIME_SLOTS    = 10;
    localparam int QUEUE_DEPTH    = 2;

    localparam int DIGIT_W   = 4;
    localparam int CHAIN_W   = 5;
    localparam int RES_W     = 5;
    localparam int MASK_W    = 10;
    localparam int BITLEN_W  = 10;
    localparam int PIDX_W    = 4;
    localparam int KSTEP_W   = 5;
    localparam int VERDICT_W = 2;
    localparam int DCOUNT_W  = 8;
    localparam int LDB_W     = 3;

    // Raw bit length is at most 254 * 4 + 4; the cap may need more bits.
    localparam int BL_RAW_W = 11;
    localparam int BL_CAP_W = $clog2(MAX_BIT_LENGTH + 1);
    localparam int BL_W     = (BL_CAP_W > BL_RAW_W) ? BL_CAP_W : BL_RAW_W;

    localparam int KILL_W = $clog2(CHAIN_MAX);
    localparam int KE_W   = KILL_W + 1;
    localparam int CMP_W  = (KILL_W > CHAIN_W) ? KILL_W : CHAIN_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_MIN_BIT_LENGTH   = 1'b0;
    localparam logic REG_MIN_CHAIN_LENGTH = 1'b1;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_IMMUNE,
        VERDICT_NEVER,
        VERDICT_INSIDE,
        VERDICT_BEYOND
    } verdict_t;

    localparam logic [RES_W-1:0] PRIME_TAB [PRIME_SLOTS] = '{
        5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29, 5'd31
    };

    typedef logic [NUM_PRIMES-1:0][RES_W-1:0] res_vec_t;

    typedef struct packed {
        res_vec_t             residues;
        logic [BITLEN_W-1:0]  bit_length;
        logic [CHAIN_W-1:0]   chain_length;
        logic                 filtered;
    } root_job_t;

    typedef struct packed {
        logic      valid;
        root_job_t job;
    } job_head_t;

    // Kill table entry: top bit set means no kill inside the search window.
    typedef logic [31:0][KE_W-1:0]      kill_row_t;
    typedef kill_row_t [NUM_PRIMES-1:0] kill_tab_t;

    // One digit into a residue: shift in one bit at a time, reducing each step.
    function automatic logic [RES_W-1:0] res_update(
        input logic [RES_W-1:0]   r,
        input logic [DIGIT_W-1:0] d,
        input logic [RES_W-1:0]   q
    );
        logic [RES_W:0]   t;
        logic [RES_W-1:0] acc;
        acc = r;
        for (int b = DIGIT_W - 1; b >= 0; b--) begin
            t = {acc, d[b]};
            if (t >= {1'b0, q}) begin
                t = t - {1'b0, q};
            end
            acc = t[RES_W-1:0];
        end
        return acc;
    endfunction

    function automatic logic [LDB_W-1:0] bits_of_digit(input logic [DIGIT_W-1:0] d);
        logic [LDB_W-1:0] n;
        case (d) inside
            [4'd8:4'd15]: n = 3'd4;
            [4'd4:4'd7]:  n = 3'd3;
            [4'd2:4'd3]:  n = 3'd2;
            4'd1:         n = 3'd1;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic kill_tab_t build_kill_tab();
        kill_tab_t       tab;
        int              q;
        int              v;
        logic            found;
        logic [KE_W-1:0] entry;
        for (int i = 0; i < NUM_PRIMES; i++) begin
            q = int'(PRIME_TAB[i]);
            for (int pp = 0; pp < 32; pp++) begin
                entry = {1'b1, {KILL_W{1'b0}}};
                if (pp != 0 && pp < q) begin
                    v = pp;
                    found = 1'b0;
                    for (int j = 0; j < CHAIN_MAX; j++) begin
                        if (!found && v == 1) begin
                            entry = {1'b0, KILL_W'(j)};
                            found = 1'b1;
                        end
                        v = v * 2;
                        if (v >= q) begin
                            v = v - q;
                        end
                    end
                end
                tab[i][pp] = entry;
            end
        end
        return tab;
    endfunction

    localparam kill_tab_t KILL_TAB = build_kill_tab();

endpackage

// ----- hw/rtl/crspc_front.sv -----
// Digit intake: running residues, digit count and bit length, root filter.
`timescale 1ns / 1ps
module crspc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [crspc_pkg::DIGIT_W-1:0] hex_digit,
    input  logic [crspc_pkg::CHAIN_W-1:0] chain_length,
    input  logic                          final_digit,
    input  logic [crspc_pkg::BITLEN_W-1:0] min_bit_length,
    input  logic [crspc_pkg::CHAIN_W-1:0] min_chain_length,
    output logic                          push,
    output crspc_pkg::root_job_t          push_job
);
    import crspc_pkg::*;

    res_vec_t             res_reg;
    res_vec_t             res_next;
    logic [DCOUNT_W-1:0]  dcount_reg;
    logic [DCOUNT_W-1:0]  dcount_next;
    logic [LDB_W-1:0]     ldb_reg;
    logic [LDB_W-1:0]     ldb_next;
    logic [BL_RAW_W-1:0]  bl_raw;
    logic [BL_W-1:0]      bl_capped;
    logic [DCOUNT_W-1:0]  dcount_m1;

    always_comb
    begin
        for (int i = 0; i < NUM_PRIMES; i++) begin
            res_next[i] = res_update(res_reg[i], hex_digit, PRIME_TAB[i]);
        end
    end

    assign dcount_next = (dcount_reg == {DCOUNT_W{1'b1}}) ? dcount_reg
                                                          : dcount_reg + 1'b1;
    assign ldb_next    = (dcount_reg == '0) ? bits_of_digit(hex_digit) : ldb_reg;
    assign dcount_m1   = dcount_next - 1'b1;

    always_comb
    begin
        bl_raw = {1'b0, dcount_m1, 2'b00} + BL_RAW_W'(ldb_next);
        if (BL_W'(bl_raw) > BL_W'(MAX_BIT_LENGTH)) begin
            bl_capped = BL_W'(MAX_BIT_LENGTH);
        end else begin
            bl_capped = BL_W'(bl_raw);
        end
    end

    assign push = accept && final_digit;

    always_comb
    begin
        push_job.residues     = res_next;
        push_job.bit_length   = bl_capped[BITLEN_W-1:0];
        push_job.chain_length = chain_length;
        push_job.filtered     = (bl_capped < BL_W'(min_bit_length))
                             || (chain_length < min_chain_length);
    end

    // The final digit hands the root to the queue and clears for the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_reg    <= '0;
            dcount_reg <= '0;
            ldb_reg    <= '0;
        end else if (accept) begin
            if (final_digit) begin
                res_reg    <= '0;
                dcount_reg <= '0;
                ldb_reg    <= '0;
            end else begin
                res_reg    <= res_next;
                dcount_reg <= dcount_next;
                ldb_reg    <= ldb_next;
            end
        end
    end

endmodule

// ----- hw/rtl/crspc_queue.sv -----
// Short queue of classified roots between the intake and the result side.
`timescale 1ns / 1ps
module crspc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  crspc_pkg::root_job_t push_job,
    input  logic                 pop,
    output crspc_pkg::job_head_t head,
    output logic                 full
);
    import crspc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    root_job_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_pop;

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        head.valid = (count_reg != '0);
        head.job   = slot_reg[rd_ptr_reg];
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hw/rtl/crspc_back.sv -----
// Result side: walks the head root's primes; one item a cycle while not stalled.
`timescale 1ns / 1ps
module crspc_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  crspc_pkg::job_head_t             head,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [crspc_pkg::PIDX_W-1:0]     prime_index,
    output logic [crspc_pkg::RES_W-1:0]      residue_plus_one,
    output logic [crspc_pkg::KSTEP_W-1:0]    kill_step,
    output logic [crspc_pkg::VERDICT_W-1:0]  verdict,
    output logic                             safe_flag,
    output logic [crspc_pkg::MASK_W-1:0]     immunity_mask,
    output logic [crspc_pkg::BITLEN_W-1:0]   bit_length,
    output logic                             filtered,
    output logic                             last_result
);
    import crspc_pkg::*;

    logic [PIDX_W-1:0]    idx_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [MASK_W-1:0]    mask_acc;
    logic                 valid_reg;
    logic                 load;
    logic                 last;

    logic [RES_W-1:0]     pp1     [NUM_PRIMES];
    logic [KE_W-1:0]      kentry  [NUM_PRIMES];
    logic [RES_W-1:0]     sel_pp1;
    logic [KE_W-1:0]      sel_ke;
    logic                 sel_immune;
    verdict_t             verdict_c;
    logic [KSTEP_W-1:0]   kstep_c;

    logic [PIDX_W-1:0]    pidx_out_reg;
    logic [RES_W-1:0]     pp1_out_reg;
    logic [KSTEP_W-1:0]   kstep_out_reg;
    verdict_t             verdict_out_reg;
    logic [MASK_W-1:0]    mask_out_reg;
    logic [BITLEN_W-1:0]  bl_out_reg;
    logic                 filt_out_reg;
    logic                 last_out_reg;

    // Every prime gets its own table lookup; the prime index then selects one.
    always_comb
    begin
        for (int i = 0; i < NUM_PRIMES; i++) begin
            pp1[i]    = (head.job.residues[i] == PRIME_TAB[i] - 1'b1) ? '0
                                                                       : head.job.residues[i] + 1'b1;
            kentry[i] = KILL_TAB[i][pp1[i]];
        end
    end

    always_comb
    begin
        sel_pp1 = '0;
        sel_ke  = '0;
        for (int i = 0; i < NUM_PRIMES; i++) begin
            if (idx_reg == PIDX_W'(i)) begin
                sel_pp1 = pp1[i];
                sel_ke  = kentry[i];
            end
        end
    end

    assign sel_immune = (sel_pp1 == '0);
    assign mask_acc   = sel_immune ? (mask_reg | (MASK_W'(1) << idx_reg)) : mask_reg;

    always_comb
    begin
        kstep_c = '0;
        if (sel_immune) begin
            verdict_c = VERDICT_IMMUNE;
        end else if (sel_ke[KE_W-1]) begin
            verdict_c = VERDICT_NEVER;
        end else begin
            kstep_c = KSTEP_W'(sel_ke[KILL_W-1:0]);
            if (CMP_W'(sel_ke[KILL_W-1:0]) >= CMP_W'(head.job.chain_length)) begin
                verdict_c = VERDICT_BEYOND;
            end else begin
                verdict_c = VERDICT_INSIDE;
            end
        end
    end

    assign last = head.job.filtered || (idx_reg == PIDX_W'(NUM_PRIMES - 1));
    assign load = head.valid && (!valid_reg || !out_stall);
    assign pop  = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            mask_reg  <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                if (last) begin
                    idx_reg  <= '0;
                    mask_reg <= '0;
                end else begin
                    idx_reg  <= idx_reg + 1'b1;
                    mask_reg <= mask_acc;
                end
            end else if (!out_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            bl_out_reg   <= head.job.bit_length;
            filt_out_reg <= head.job.filtered;
            last_out_reg <= last;
            if (head.job.filtered) begin
                pidx_out_reg    <= '0;
                pp1_out_reg     <= '0;
                kstep_out_reg   <= '0;
                verdict_out_reg <= VERDICT_IMMUNE;
                mask_out_reg    <= '0;
            end else begin
                pidx_out_reg    <= idx_reg;
                pp1_out_reg     <= sel_pp1;
                kstep_out_reg   <= kstep_c;
                verdict_out_reg <= verdict_c;
                mask_out_reg    <= mask_acc;
            end
        end
    end

    // A filtered item has its verdict forced to immune, but it is never reported as safe.
    assign out_valid        = valid_reg;
    assign prime_index      = pidx_out_reg;
    assign residue_plus_one = pp1_out_reg;
    assign kill_step        = kstep_out_reg;
    assign verdict          = verdict_out_reg;
    assign safe_flag        = !filt_out_reg && (verdict_out_reg != VERDICT_INSIDE);
    assign immunity_mask    = mask_out_reg;
    assign bit_length       = bl_out_reg;
    assign filtered         = filt_out_reg;
    assign last_result      = last_out_reg;

endmodule

// ----- hw/rtl/chain_root_small_prime_classifier.sv -----
// The first result of a root passes the root queue's count register and the result
// side's output register before out_valid rises, when the result side is idle.
// One digit is taken per cycle; a root gives one filtered result or one result per
// prime, issued one per cycle from the queue head while out_stall is low.
// Digits stall only while the two-entry root queue is full.
// Reset (rst_n low, asynchronous) clears residues, counters, queue, output valid and
// both filter registers to zero.
`timescale 1ns / 1ps
`include "chain_root_small_prime_classifier_defines.svh"
module chain_root_small_prime_classifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [crspc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [crspc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [crspc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [crspc_pkg::DIGIT_W-1:0]        hex_digit,
    input  logic [crspc_pkg::CHAIN_W-1:0]        chain_length,
    input  logic                                 final_digit,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [crspc_pkg::PIDX_W-1:0]         prime_index,
    output logic [crspc_pkg::RES_W-1:0]          residue_plus_one,
    output logic [crspc_pkg::KSTEP_W-1:0]        kill_step,
    output logic [crspc_pkg::VERDICT_W-1:0]      verdict,
    output logic                                 safe_flag,
    output logic [crspc_pkg::MASK_W-1:0]         immunity_mask,
    output logic [crspc_pkg::BITLEN_W-1:0]       bit_length,
    output logic                                 filtered,
    output logic                                 last_result
);
    import crspc_pkg::*;

    logic [BITLEN_W-1:0] min_bl_reg;
    logic [CHAIN_W-1:0]  min_cl_reg;
    logic                cfg_write;
    logic                in_accept;
    logic                push;
    root_job_t           push_job;
    job_head_t           head;
    logic                pop;
    logic                queue_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_bl_reg <= '0;
            min_cl_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_MIN_BIT_LENGTH) begin
                min_bl_reg <= pwdata[BITLEN_W-1:0];
            end else begin
                min_cl_reg <= pwdata[CHAIN_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_MIN_BIT_LENGTH) ? APB_DATA_W'(min_bl_reg)
                                                     : APB_DATA_W'(min_cl_reg);

    assign in_stall  = queue_full;
    assign in_accept = in_valid && !in_stall;

    crspc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (in_accept),
        .hex_digit        (hex_digit),
        .chain_length     (chain_length),
        .final_digit      (final_digit),
        .min_bit_length   (min_bl_reg),
        .min_chain_length (min_cl_reg),
        .push             (push),
        .push_job         (push_job)
    );

    crspc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (queue_full)
    );

    crspc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .prime_index      (prime_index),
        .residue_plus_one (residue_plus_one),
        .kill_step        (kill_step),
        .verdict          (verdict),
        .safe_flag        (safe_flag),
        .immunity_mask    (immunity_mask),
        .bit_length       (bit_length),
        .filtered         (filtered),
        .last_result      (last_result)
    );

    // A root's results follow each other back to back once one has been taken.
    `CRSPC_ASSERT_NEXT(a_results_contiguous, out_valid && !out_stall && !last_result, out_valid, "result train of a root broke off")
    `CRSPC_ASSERT_NOW(a_filtered_alone, out_valid && filtered, last_result && (immunity_mask == '0), "filtered item is not a lone last result")
    `CRSPC_ASSERT_NOW(a_kill_only_when_killed, out_valid && (verdict == VERDICT_IMMUNE || verdict == VERDICT_NEVER), kill_step == '0, "kill step set without a kill")

endmodule
